// ===== rtl/core/sfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Saturating fixed-point divider package
// Shared field width and the control word that moves along the pipeline.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int FIELD_BITS = 32;

  typedef struct packed {
    logic valid;
    logic neg;
    logic sat;
  } sfd_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/sfd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Operand channel
// Valid/ready channel carrying one dividend and divisor pair per transaction.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  import sfd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] dividend;
  logic signed [FIELD_BITS-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sfd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one quotient and saturation flag per transaction.
// ----------------------------------------------------------------------------
interface sfd_out_if;
  import sfd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] quotient;
  logic                         saturated;

  modport source (output valid, output quotient, output saturated, input ready);
  modport sink (input valid, input quotient, input saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sfd_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring division stage
// Produces one quotient bit per stage with one trial subtraction.
// ----------------------------------------------------------------------------
module sfd_div_stage #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int QUO_BITS  = 30,
  parameter int BIT_INDEX = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  sfd_pkg::sfd_ctrl_t     prev_ctrl,
  input  logic [WORD_BITS-1:0]   prev_rem,
  input  logic [WORD_BITS-1:0]   prev_ma,
  input  logic [WORD_BITS-1:0]   prev_mb,
  input  logic [QUO_BITS-1:0]    prev_quo,
  output sfd_pkg::sfd_ctrl_t     ctrl,
  output logic [WORD_BITS-1:0]   rem,
  output logic [WORD_BITS-1:0]   ma,
  output logic [WORD_BITS-1:0]   mb,
  output logic [QUO_BITS-1:0]    quo
);
  import sfd_pkg::*;

  logic                 num_bit;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS+1:0] diff;
  logic                 fits;

  generate
    if (BIT_INDEX >= FRAC_BITS) begin : g_num_bit
      assign num_bit = prev_ma[BIT_INDEX-FRAC_BITS];
    end else begin : g_num_zero
      assign num_bit = 1'b0;
    end
  endgenerate

  assign trial = {prev_rem, num_bit};
  assign diff  = {1'b0, trial} - {2'b00, prev_mb};
  assign fits  = !diff[WORD_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl <= prev_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      quo <= {prev_quo[QUO_BITS-2:0], fits};
      ma  <= prev_ma;
      mb  <= prev_mb;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/saturating_fixed_point_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Saturating fixed-point divider
// Signed fixed-point divide, quotient truncated toward zero, with clamping.
//
// Operands arrive on the operands channel and each quotient leaves on the
// result channel, one result transaction for every operand transaction, in
// order. The front stage takes magnitudes and evaluates the overflow guard
// (dividend magnitude shifted right by FRAC_BITS-2 at least the divisor
// magnitude, which includes a zero divisor). A chain of restoring division
// stages then produces one quotient bit each, and an output register applies
// the sign or the clamp. The quotient has QUO_BITS bits, where QUO_BITS is
// the smaller of 2*FRAC_BITS-2 and WORD_BITS+FRAC_BITS. One transaction is
// accepted every cycle while the receiver does not stall.
// Reset clears all stage valid bits. When the receiver stalls with a result
// waiting, the whole pipeline holds and operands.ready drops until the
// result is taken; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module saturating_fixed_point_divider #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  sfd_in_if.sink   operands,
  sfd_out_if.source result
);
  import sfd_pkg::*;

  localparam int GUARD_SHIFT = FRAC_BITS - 2;
  localparam int QUO_BITS    = (2 * FRAC_BITS - 2 < WORD_BITS + FRAC_BITS) ?
                               2 * FRAC_BITS - 2 : WORD_BITS + FRAC_BITS;
  localparam int NUM_BITS    = WORD_BITS + FRAC_BITS;

  logic                   en;
  logic [WORD_BITS-1:0]   a_word;
  logic [WORD_BITS-1:0]   b_word;
  logic [WORD_BITS-1:0]   a_mag;
  logic [WORD_BITS-1:0]   b_mag;
  logic [NUM_BITS-1:0]    num_top;
  sfd_ctrl_t              front_ctrl;

  sfd_ctrl_t              ctrl_s [0:QUO_BITS];
  logic [WORD_BITS-1:0]   rem_s  [0:QUO_BITS];
  logic [WORD_BITS-1:0]   ma_s   [0:QUO_BITS];
  logic [WORD_BITS-1:0]   mb_s   [0:QUO_BITS];
  logic [QUO_BITS-1:0]    quo_s  [0:QUO_BITS];

  logic [WORD_BITS-1:0]   mag_q;
  logic [WORD_BITS-1:0]   word_q;
  logic [FIELD_BITS-1:0]  quotient_next;

  assign en             = !result.valid || result.ready;
  assign operands.ready = en;

  assign a_word = operands.dividend[WORD_BITS-1:0];
  assign b_word = operands.divisor[WORD_BITS-1:0];
  assign a_mag  = a_word[WORD_BITS-1] ? (~a_word + 1'b1) : a_word;
  assign b_mag  = b_word[WORD_BITS-1] ? (~b_word + 1'b1) : b_word;

  assign num_top = {a_mag, {FRAC_BITS{1'b0}}} >> QUO_BITS;

  always_comb begin
    front_ctrl.valid = operands.valid;
    front_ctrl.neg   = a_word[WORD_BITS-1] ^ b_word[WORD_BITS-1];
    front_ctrl.sat   = (a_mag >> GUARD_SHIFT) >= b_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_s[0] <= '0;
    end else if (en) begin
      ctrl_s[0] <= front_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= num_top[WORD_BITS-1:0];
      ma_s[0]  <= a_mag;
      mb_s[0]  <= b_mag;
    end
  end

  assign quo_s[0] = '0;

  generate
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      sfd_div_stage #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .QUO_BITS  (QUO_BITS),
        .BIT_INDEX (QUO_BITS - 1 - k)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .prev_ctrl (ctrl_s[k]),
        .prev_rem  (rem_s[k]),
        .prev_ma   (ma_s[k]),
        .prev_mb   (mb_s[k]),
        .prev_quo  (quo_s[k]),
        .ctrl      (ctrl_s[k+1]),
        .rem       (rem_s[k+1]),
        .ma        (ma_s[k+1]),
        .mb        (mb_s[k+1]),
        .quo       (quo_s[k+1])
      );
    end
  endgenerate

  assign mag_q = WORD_BITS'(quo_s[QUO_BITS]);

  always_comb begin
    priority if (ctrl_s[QUO_BITS].sat) begin
      word_q = ctrl_s[QUO_BITS].neg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                    : {1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (ctrl_s[QUO_BITS].neg) begin
      word_q = ~mag_q + 1'b1;
    end else begin
      word_q = mag_q;
    end
    quotient_next = FIELD_BITS'(signed'(word_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= ctrl_s[QUO_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.quotient  <= quotient_next;
      result.saturated <= ctrl_s[QUO_BITS].sat;
    end
  end

endmodule
`default_nettype wire

// ===== test/sfd_quotient_board_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quotient scoreboard
// Computes the expected quotient and saturation flag for every accepted
// operand pair and compares each result transaction against them in order.
// ----------------------------------------------------------------------------
package sfd_quotient_board_pkg;
  import sfd_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int GUARD_SHIFT = FRAC_BITS - 2;

  localparam logic [FIELD_BITS-1:0] MOST_NEG_WORD = {1'b1, {(FIELD_BITS-1){1'b0}}};
  localparam logic [FIELD_BITS-1:0] MOST_POS_WORD = {1'b0, {(FIELD_BITS-1){1'b1}}};

  typedef struct packed {
    logic [FIELD_BITS-1:0] quotient;
    logic                  saturated;
  } quotient_t;

  class quotient_board;
    quotient_t pending[$];
    int        failures;

    function new();
      failures = 0;
    endfunction

    function automatic quotient_t divide_expected(logic signed [FIELD_BITS-1:0] a,
                                                  logic signed [FIELD_BITS-1:0] b);
      logic signed [FIELD_BITS:0] ax;
      logic signed [FIELD_BITS:0] bx;
      logic [FIELD_BITS:0]        ma;
      logic [FIELD_BITS:0]        mb;
      logic [63:0]                mq;
      logic                       neg;
      quotient_t                  r;
      ax  = a;
      bx  = b;
      ma  = (ax < 0) ? -ax : ax;
      mb  = (bx < 0) ? -bx : bx;
      neg = a[FIELD_BITS-1] ^ b[FIELD_BITS-1];
      if ((ma >> GUARD_SHIFT) >= mb) begin
        r.quotient  = neg ? MOST_NEG_WORD : MOST_POS_WORD;
        r.saturated = 1'b1;
      end else begin
        mq          = (64'(ma) << FRAC_BITS) / 64'(mb);
        r.quotient  = neg ? -mq[FIELD_BITS-1:0] : mq[FIELD_BITS-1:0];
        r.saturated = 1'b0;
      end
      return r;
    endfunction

    function void note_operands(logic signed [FIELD_BITS-1:0] a,
                                logic signed [FIELD_BITS-1:0] b);
      pending.push_back(divide_expected(a, b));
    endfunction

    function void check_result(logic [FIELD_BITS-1:0] q, logic s);
      quotient_t want;
      if (pending.size() == 0) begin
        failures++;
        $display("%0t: unexpected result transaction quotient %h saturated %b",
                 $time, q, s);
        return;
      end
      want = pending.pop_front();
      if (q !== want.quotient) begin
        failures++;
        $display("%0t: quotient mismatch, expected %h actual %h",
                 $time, want.quotient, q);
      end
      if (s !== want.saturated) begin
        failures++;
        $display("%0t: saturated mismatch, expected %b actual %b",
                 $time, want.saturated, s);
      end
    endfunction
  endclass

endpackage

// ===== test/saturating_fixed_point_divider_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating fixed-point divider testbench
// Drives directed corner pairs and about 1450 random operand pairs with random
// gaps on the sender and random stalls on the receiver, and checks every
// quotient and saturation flag in order against a scoreboard.
// ----------------------------------------------------------------------------
module saturating_fixed_point_divider_test;
  import sfd_pkg::*;
  import sfd_quotient_board_pkg::*;

  localparam int RANDOM_PAIRS = 1450;
  localparam int DRAIN_CYCLES = 40;

  typedef logic signed [FIELD_BITS-1:0] word_t;

  logic clk;
  logic rst;
  logic send_calm;
  logic recv_calm;

  sfd_in_if  operands();
  sfd_out_if result();

  quotient_board board;

  saturating_fixed_point_divider dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap(logic calm);
    if (calm)
      return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic word_t with_random_sign(word_t v);
    if ($urandom_range(0, 1))
      return -v;
    return v;
  endfunction

  task automatic send_pair(word_t a, word_t b);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      operands.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operands.valid    <= 1'b1;
    operands.dividend <= a;
    operands.divisor  <= b;
    @(posedge clk);
    while (!operands.ready) @(posedge clk);
    board.note_operands(a, b);
  endtask

  task automatic send_random_pair();
    word_t                   a;
    word_t                   b;
    logic [FIELD_BITS:0]     ma;
    logic signed [FIELD_BITS:0] ax;
    int                      kind;
    kind = $urandom_range(0, 3);
    a    = $urandom;
    case (kind)
      0: begin
        b = $urandom;
      end
      1: begin
        b = with_random_sign(word_t'($urandom >> $urandom_range(16, 31)));
      end
      2: begin
        ax = a;
        ma = (ax < 0) ? -ax : ax;
        b  = word_t'((ma >> GUARD_SHIFT) + $urandom_range(0, 2)) - 1;
        b  = with_random_sign(b);
      end
      default: begin
        a = with_random_sign(word_t'($urandom >> $urandom_range(0, 31)));
        b = with_random_sign(word_t'($urandom >> $urandom_range(0, 31)));
      end
    endcase
    send_pair(a, b);
  endtask

  initial begin
    forever begin
      int gap;
      @(negedge rst);
      forever begin
        gap = draw_gap(recv_calm);
        if (gap > 0) begin
          result.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        result.ready <= 1'b1;
        @(posedge clk);
        while (!result.valid) @(posedge clk);
        board.check_result(result.quotient, result.saturated);
      end
    end
  end

  initial begin
    board = new();
    send_calm          = 1'b0;
    recv_calm          = 1'b0;
    rst               <= 1'b1;
    operands.valid    <= 1'b0;
    operands.dividend <= '0;
    operands.divisor  <= '0;
    result.ready      <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(32'sh0001_0000, 32'sh0001_0000);
    send_pair(-32'sh0003_0000, 32'sh0002_0000);
    send_pair(32'sh0000_0000, 32'sh0000_0001);
    send_pair(32'sh0000_0000, 32'sh0000_0000);
    send_pair(32'sh0001_0000, 32'sh0000_0000);
    send_pair(-32'sh0000_0001, 32'sh0000_0000);
    send_pair(MOST_NEG_WORD, 32'sh0000_0000);
    send_pair(MOST_NEG_WORD, MOST_NEG_WORD);
    send_pair(MOST_POS_WORD, MOST_POS_WORD);
    send_pair(MOST_POS_WORD, MOST_NEG_WORD);
    send_pair(MOST_NEG_WORD, MOST_POS_WORD);
    send_pair(MOST_NEG_WORD, 32'sh0000_0001);
    send_pair(MOST_NEG_WORD, -32'sh0000_0001);
    send_pair(MOST_POS_WORD, -32'sh0000_0001);
    send_pair(32'sh0000_0001, MOST_NEG_WORD);
    send_pair(-32'sh0000_0001, MOST_POS_WORD);
    send_pair(32'sh0004_0000, 32'sh0000_0010);
    send_pair(32'sh0004_0000, 32'sh0000_0011);
    send_pair(-32'sh0004_0000, 32'sh0000_0011);
    send_pair(32'sh0003_FFFF, -32'sh0000_000F);
    send_pair(32'sh0003_FFFF, 32'sh0000_0010);
    send_pair(-32'sh0000_8000, -32'sh0001_8000);
    send_pair(32'sh7FFF_0000, 32'sh0002_0001);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 64 == 0) begin
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      send_random_pair();
    end
    operands.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("saturating_fixed_point_divider verification clean");
    end else begin
      $display("saturating_fixed_point_divider verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("saturating_fixed_point_divider verification failed");
    $finish;
  end

endmodule
